### rtl/core/fpst_pkg.sv
// Shared constants, types and the quarter-wave table of the fixed-point sine block.
package fpst_pkg;

    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int ANGLE_W = 32;
    localparam int SINE_W  = 12;
    localparam int AMP_W   = 11;
    localparam int FOLD_W  = 12;
    localparam int RED_W   = 14;
    localparam int SUM_W   = 26;
    localparam int QUO_W   = 12;
    localparam int IDX_W   = 6;
    localparam int FRAC_W  = 7;
    localparam int DIFF_W  = 7;
    localparam int NUM_W   = 14;

    localparam int TABLE_STEPS = 32;
    localparam int ANG_HALF_PI = 3200;
    localparam int ANG_PI      = 6399;
    localparam int ANG_TWO_PI  = 12799;
    localparam int ANG_STEP    = ANG_HALF_PI / TABLE_STEPS;

    localparam int WRAP_16     = (1 << 16) % ANG_TWO_PI;
    localparam int RECIP_SH    = 40;
    localparam longint RECIP   = (64'd1 << RECIP_SH) / ANG_TWO_PI;
    localparam int RECIP_W     = 27;
    localparam int STEP_SH     = 19;
    localparam int STEP_MUL    = ((1 << STEP_SH) + ANG_STEP - 1) / ANG_STEP;
    localparam int STEP_MUL_W  = 13;

    typedef struct packed {
        logic              neg;
        logic [FOLD_W-1:0] angle_fold;
    } fpst_mid_t;

    function automatic logic [AMP_W-1:0] quarter_wave(input logic [IDX_W-1:0] i);
        logic [AMP_W-1:0] v;
        unique case (i)
            6'd0:    v = 11'd0;
            6'd1:    v = 11'd100;
            6'd2:    v = 11'd200;
            6'd3:    v = 11'd299;
            6'd4:    v = 11'd397;
            6'd5:    v = 11'd495;
            6'd6:    v = 11'd591;
            6'd7:    v = 11'd686;
            6'd8:    v = 11'd780;
            6'd9:    v = 11'd871;
            6'd10:   v = 11'd960;
            6'd11:   v = 11'd1047;
            6'd12:   v = 11'd1132;
            6'd13:   v = 11'd1214;
            6'd14:   v = 11'd1292;
            6'd15:   v = 11'd1368;
            6'd16:   v = 11'd1440;
            6'd17:   v = 11'd1509;
            6'd18:   v = 11'd1575;
            6'd19:   v = 11'd1636;
            6'd20:   v = 11'd1694;
            6'd21:   v = 11'd1747;
            6'd22:   v = 11'd1797;
            6'd23:   v = 11'd1841;
            6'd24:   v = 11'd1882;
            6'd25:   v = 11'd1918;
            6'd26:   v = 11'd1949;
            6'd27:   v = 11'd1976;
            6'd28:   v = 11'd1998;
            6'd29:   v = 11'd2015;
            6'd30:   v = 11'd2027;
            6'd31:   v = 11'd2035;
            default: v = 11'd2037;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/fixed_point_sine_table_interp.sv
// Top level of the fixed-point sine block: front, middle queue, back and result queue.
//
// The block turns an angle in radians times 2037 into its sine times 2037.
// Input words are offered on angle with push; a word is taken at a clock edge
// where push is high and full is low. Results leave through a queue: while
// empty is low the oldest sine is on the sine port, and it is taken at an
// edge where pop is high.
// One word is taken per clock cycle, sustained, while full stays low. A taken
// word passes the six stages of modulo reduction and folding, a write into
// the middle queue, six stages of table lookup and interpolation, and a
// write into the result queue, after which it can leave; the back section
// takes it from the middle queue only while the result queue has room.
// Each section admits a word only while it holds a free place in the queue
// that follows it, so if the receiver stops popping, the result queue and
// then the middle queue fill and full rises; nothing is dropped.
// Reset empties both queues and clears all pipeline valid bits; the block
// takes words again as soon as reset is released.
module fixed_point_sine_table_interp
    import fpst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [SINE_W-1:0]  sine
);

    fpst_mid_t           front_word;
    logic                front_push;
    logic                mid_empty;
    logic                mid_pop;
    fpst_mid_t           mid_word;
    logic                back_push;
    logic [SINE_W-1:0]   back_sine;
    logic [SINE_W-1:0]   out_word;
    logic                out_pop;

    assign out_pop = pop && !empty;

    fpst_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .angle    (angle),
        .full     (full),
        .mid_pop  (mid_pop),
        .mid_push (front_push),
        .mid_word (front_word)
    );

    fpst_fifo #(
        .WIDTH ($bits(fpst_mid_t))
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .wr_data (front_word),
        .pop     (mid_pop),
        .empty   (mid_empty),
        .rd_data (mid_word)
    );

    fpst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_word  (mid_word),
        .mid_pop   (mid_pop),
        .out_pop   (out_pop),
        .out_push  (back_push),
        .out_sine  (back_sine)
    );

    fpst_fifo #(
        .WIDTH (SINE_W)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (back_push),
        .wr_data (back_sine),
        .pop     (out_pop),
        .empty   (empty),
        .rd_data (out_word)
    );

    assign sine = out_word;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) mid_pop |-> !mid_empty)
        else $error("Back section took a word from an empty middle queue.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !mid_empty |-> (mid_word.angle_fold <= FOLD_W'(ANG_HALF_PI)))
        else $error("Folded angle lies outside the first quadrant.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((sine <= 12'sd2037) && (sine >= -12'sd2037)))
        else $error("Sine result lies outside its range.");
`endif

endmodule

### rtl/core/fpst_fifo.sv
// Small register queue used between the pipeline sections and at the output.
module fpst_fifo
    import fpst_pkg::*;
#(
    parameter int WIDTH = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_next;
    logic [Q_CW-1:0]  cnt_reg;
    logic [Q_CW-1:0]  cnt_next;
    logic             pop_ok;

    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign pop_ok  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CW'(push) - Q_CW'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/core/fpst_front.sv
// Front section: takes the angle magnitude, reduces it modulo two pi and folds it.
module fpst_front
    import fpst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic                      full,
    input  logic                      mid_pop,
    output logic                      mid_push,
    output fpst_mid_t                 mid_word
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg;
    logic [Q_CW-1:0]   credit_reg;
    logic [Q_CW-1:0]   credit_next;
    logic              admit;

    logic [ANGLE_W-1:0] angle_u;
    logic [ANGLE_W-1:0] mag;
    logic [SUM_W:0]     sum_full;
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [SUM_W-1:0]   qm;
    logic [SUM_W-1:0]   diff;
    logic [RED_W-1:0]   red;
    logic [RED_W-1:0]   half;
    logic               flip;
    logic [FOLD_W-1:0]  fold;

    logic [ANGLE_W-1:0] mag1_reg;
    logic               neg1_reg;
    logic [SUM_W-1:0]   t2_reg;
    logic               neg2_reg;
    logic [QUO_W-1:0]   q3_reg;
    logic [SUM_W-1:0]   t3_reg;
    logic               neg3_reg;
    logic [SUM_W-1:0]   qm4_reg;
    logic [SUM_W-1:0]   t4_reg;
    logic               neg4_reg;
    logic [RED_W-1:0]   r5_reg;
    logic               neg5_reg;
    logic [FOLD_W-1:0]  x6_reg;
    logic               neg6_reg;

    assign full        = (credit_reg == Q_CW'(Q_DEPTH));
    assign admit       = push && !full;
    assign credit_next = credit_reg + Q_CW'(admit) - Q_CW'(mid_pop);

    always_comb
    begin
        angle_u  = angle;
        mag      = angle_u[ANGLE_W-1] ? (32'd0 - angle_u) : angle_u;
        sum_full = {11'd0, mag1_reg[31:16]} * (SUM_W+1)'(WRAP_16)
                   + (SUM_W+1)'(mag1_reg[15:0]);
        prod     = {{RECIP_W{1'b0}}, t2_reg} * (SUM_W+RECIP_W)'(RECIP);
        qm       = {{(SUM_W-QUO_W){1'b0}}, q3_reg} * SUM_W'(ANG_TWO_PI);
        diff     = t4_reg - qm4_reg;
        red      = (diff >= SUM_W'(ANG_TWO_PI)) ? RED_W'(diff - SUM_W'(ANG_TWO_PI))
                                                 : RED_W'(diff);
        flip     = (r5_reg > RED_W'(ANG_PI));
        half     = flip ? (RED_W'(ANG_TWO_PI) - r5_reg) : r5_reg;
        fold     = (half > RED_W'(ANG_HALF_PI)) ? FOLD_W'(RED_W'(ANG_PI) - half)
                                                : FOLD_W'(half);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            credit_reg <= '0;
        end
        else
        begin
            vld_reg    <= {vld_reg[STAGES-2:0], admit};
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag1_reg <= mag;
        neg1_reg <= angle_u[ANGLE_W-1];
        t2_reg   <= SUM_W'(sum_full);
        neg2_reg <= neg1_reg;
        q3_reg   <= prod[RECIP_SH +: QUO_W];
        t3_reg   <= t2_reg;
        neg3_reg <= neg2_reg;
        qm4_reg  <= qm;
        t4_reg   <= t3_reg;
        neg4_reg <= neg3_reg;
        r5_reg   <= red;
        neg5_reg <= neg4_reg;
        x6_reg   <= fold;
        neg6_reg <= neg5_reg ^ flip;
    end

    assign mid_push            = vld_reg[STAGES-1];
    assign mid_word.neg        = neg6_reg;
    assign mid_word.angle_fold = x6_reg;

endmodule

### rtl/core/fpst_back.sv
// Back section: table lookup and rounded linear interpolation of the folded angle.
module fpst_back
    import fpst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     mid_empty,
    input  fpst_mid_t                mid_word,
    output logic                     mid_pop,
    input  logic                     out_pop,
    output logic                     out_push,
    output logic signed [SINE_W-1:0] out_sine
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg;
    logic [Q_CW-1:0]   credit_reg;
    logic [Q_CW-1:0]   credit_next;

    logic [FOLD_W+STEP_MUL_W-1:0] p_idx;
    logic [FOLD_W-1:0]            step_base;
    logic [AMP_W-1:0]             y_lo;
    logic [AMP_W-1:0]             y_hi;
    logic [NUM_W+STEP_MUL_W-1:0]  p_num;
    logic [AMP_W-1:0]             y_mag;

    logic [IDX_W-1:0]  idx1_reg;
    logic [FOLD_W-1:0] x1_reg;
    logic              neg1_reg;
    logic [IDX_W-1:0]  idx2_reg;
    logic [FRAC_W-1:0] frac2_reg;
    logic              neg2_reg;
    logic [AMP_W-1:0]  y3_reg;
    logic [DIFF_W-1:0] d3_reg;
    logic [FRAC_W-1:0] frac3_reg;
    logic              neg3_reg;
    logic [NUM_W-1:0]  num4_reg;
    logic [AMP_W-1:0]  y4_reg;
    logic              neg4_reg;
    logic [FRAC_W-1:0] q5_reg;
    logic [AMP_W-1:0]  y5_reg;
    logic              neg5_reg;
    logic [SINE_W-1:0] sine6_reg;

    assign mid_pop     = !mid_empty && (credit_reg != Q_CW'(Q_DEPTH));
    assign credit_next = credit_reg + Q_CW'(mid_pop) - Q_CW'(out_pop);

    always_comb
    begin
        p_idx     = {{STEP_MUL_W{1'b0}}, mid_word.angle_fold}
                    * (FOLD_W+STEP_MUL_W)'(STEP_MUL);
        step_base = {{(FOLD_W-IDX_W){1'b0}}, idx1_reg} * FOLD_W'(ANG_STEP);
        y_lo      = quarter_wave(idx2_reg);
        y_hi      = quarter_wave(idx2_reg + IDX_W'(1));
        p_num     = {{STEP_MUL_W{1'b0}}, num4_reg} * (NUM_W+STEP_MUL_W)'(STEP_MUL);
        y_mag     = y5_reg + AMP_W'(q5_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            credit_reg <= '0;
        end
        else
        begin
            vld_reg    <= {vld_reg[STAGES-2:0], mid_pop};
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg  <= p_idx[STEP_SH +: IDX_W];
        x1_reg    <= mid_word.angle_fold;
        neg1_reg  <= mid_word.neg;
        idx2_reg  <= idx1_reg;
        frac2_reg <= FRAC_W'(x1_reg - step_base);
        neg2_reg  <= neg1_reg;
        y3_reg    <= y_lo;
        if (idx2_reg >= IDX_W'(TABLE_STEPS))
        begin
            d3_reg <= '0;
        end
        else
        begin
            d3_reg <= DIFF_W'(y_hi - y_lo);
        end
        frac3_reg <= frac2_reg;
        neg3_reg  <= neg2_reg;
        num4_reg  <= NUM_W'(ANG_STEP / 2)
                     + {{(NUM_W-FRAC_W){1'b0}}, frac3_reg} * {{(NUM_W-DIFF_W){1'b0}}, d3_reg};
        y4_reg    <= y3_reg;
        neg4_reg  <= neg3_reg;
        q5_reg    <= p_num[STEP_SH +: FRAC_W];
        y5_reg    <= y4_reg;
        neg5_reg  <= neg4_reg;
        sine6_reg <= neg5_reg ? (SINE_W'(0) - {1'b0, y_mag}) : {1'b0, y_mag};
    end

    assign out_push = vld_reg[STAGES-1];
    assign out_sine = sine6_reg;

endmodule
